/* rtl/core/psrq_pkg.sv */
`timescale 1ns / 1ps

package psrq_pkg;

   // Store geometry and field widths.
   localparam int DEPTH     = 64;
   localparam int COORD_W   = 16;
   localparam int RADIUS_W  = 16;
   localparam int OP_W      = 3;
   localparam int STATUS_W  = 2;
   localparam int PCOUNT_W  = 7;
   localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int POINT_W   = 2 * COORD_W;
   localparam int SQ_W      = 2 * COORD_W;
   localparam int RADSQ_W   = 2 * RADIUS_W;
   // The radius is Q12.4, so its square carries eight fraction bits.
   localparam int LIM_W     = RADSQ_W - 8;
   localparam int CMP_W     = (SQ_W + 1 > LIM_W) ? SQ_W + 1 : LIM_W;

   // Stream widths, padded up to whole bytes.
   localparam int REQ_FIELDS_W = POINT_W + RADIUS_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = STATUS_W + PCOUNT_W + 1;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
   localparam logic [OP_W-1:0] OP_POP    = 3'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
   localparam logic [OP_W-1:0] OP_COUNT  = 3'd3;
   localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;
   localparam logic [OP_W-1:0] OP_LENGTH = 3'd5;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic push;
      logic pop;
      logic length;
      logic scan;
      logic not_found;
      logic shift_start;
      logic shift;
      logic shift_end;
      logic respond;
   } psrq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            hit;
      logic            scan_idle;
      logic            shift_idle;
      logic            rsp_free;
   } psrq_sts_type;

endpackage

/* rtl/core/point_stack_radius_query_unit.sv */
`timescale 1ns / 1ps

// Channel   Direction  Fields, lowest bit first
// req_*     in         tuser: operation[2:0]; tdata: x_coord[15:0], y_coord[31:16],
//                      radius[47:32]
// rsp_*     out        tdata: status[1:0], point_count[8:2], found[9], zero pad [15:10]
//
// Push, pop, length and unused codes pass through the execute and done states;
// ready returns as the result register is loaded. Search and count read one stored
// point per cycle, so a search that misses reads all N points; a count also drains
// the squaring and compare stages, and a remove shifts each entry above the hit down
// one slot to close the gap. Reset is synchronous and active high and empties the stack.
// A stalled result waits in the output register while the next request is accepted.

module point_stack_radius_query_unit
   import psrq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // operation[2:0]
   input  logic [OP_W-1:0]       req_tuser,
   // x_coord[15:0], y_coord[31:16], radius[47:32]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status[1:0], point_count[8:2], found[9], zeros above
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // The controller sequences each request through its states and drives the
   // datapath with commands; the datapath reports back the decoded operation,
   // the hit flag, its scan and shift progress and whether the output is free.
   psrq_cmd_type cmd;
   psrq_sts_type sts;

   psrq_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath owns the point memory, the entry count, the scan pointer,
   // the two-stage squared-distance pipeline and the result register.
   psrq_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* rtl/core/psrq_datapath.sv */
`timescale 1ns / 1ps

module psrq_datapath
   import psrq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  psrq_cmd_type          cmd,
   output psrq_sts_type          sts,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [OP_W-1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Point store, {y, x} per entry.
   logic [POINT_W-1:0] store_mem [DEPTH];

   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [POINT_W-1:0]    key_ff, key_in;
   logic [LIM_W-1:0]      lim_ff, lim_in;
   logic [CNT_W-1:0]      ptr_ff, ptr_in;
   logic [POINT_W-1:0]    rd_data_ff;
   logic                  rd_vld_ff, rd_vld_in;
   logic                  rd_shift_ff, rd_shift_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [SQ_W-1:0]       sqx_ff, sqx_in;
   logic [SQ_W-1:0]       sqy_ff, sqy_in;
   logic                  sq_vld_ff, sq_vld_in;
   logic                  hit_ff, hit_in;
   logic [IDX_W-1:0]      hit_idx_ff, hit_idx_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [CNT_W-1:0]      res_count_ff, res_count_in;
   logic                  res_found_ff, res_found_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [POINT_W-1:0]    wr_data;
   logic [CNT_W-1:0]      ptr_dec;
   logic [RADIUS_W-1:0]   radius;
   logic [RADSQ_W-1:0]    rad_sq;
   logic signed [COORD_W-1:0] rx;
   logic signed [COORD_W-1:0] ry;
   logic signed [SQ_W-1:0]    sqx_s;
   logic signed [SQ_W-1:0]    sqy_s;
   logic [SQ_W:0]         sq_sum;
   logic                  is_match_op;

   assign radius      = req_tdata[POINT_W +: RADIUS_W];
   assign rad_sq      = radius * radius;
   assign ptr_dec     = ptr_ff - CNT_W'(1);
   assign rx          = rd_data_ff[COORD_W-1:0];
   assign ry          = rd_data_ff[POINT_W-1:COORD_W];
   assign sqx_s       = rx * rx;
   assign sqy_s       = ry * ry;
   assign sq_sum      = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign is_match_op = (op_ff == OP_SEARCH) || (op_ff == OP_REMOVE);

   always_comb begin
      cnt_in        = cnt_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      lim_in        = lim_ff;
      ptr_in        = ptr_ff;
      rd_shift_in   = rd_shift_ff;
      rd_idx_in     = rd_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      res_status_in = res_status_ff;
      res_count_in  = res_count_ff;
      res_found_in  = res_found_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = key_ff;

      // Squaring stage, used by the radius count only.
      sqx_in    = sqx_s;
      sqy_in    = sqy_s;
      sq_vld_in = rd_vld_ff && !rd_shift_ff && (op_ff == OP_COUNT);

      // Compare stage for the radius count.
      if (sq_vld_ff && (CMP_W'(sq_sum) <= CMP_W'(lim_ff))) begin
         res_count_in = res_count_ff + CNT_W'(1);
      end

      // The scan runs from the top down, so the first hit is the topmost match.
      if (rd_vld_ff && !rd_shift_ff && !hit_ff && is_match_op && (rd_data_ff == key_ff)) begin
         hit_in     = 1'b1;
         hit_idx_in = rd_idx_ff;
         if (op_ff == OP_SEARCH) begin
            res_found_in = 1'b1;
         end
      end

      // A shift read returns entry n and writes it back one slot lower.
      if (rd_vld_ff && rd_shift_ff) begin
         wr_en   = 1'b1;
         wr_addr = rd_idx_ff - IDX_W'(1);
         wr_data = rd_data_ff;
      end

      if (cmd.load) begin
         op_in         = req_tuser;
         key_in        = req_tdata[POINT_W-1:0];
         lim_in        = rad_sq[RADSQ_W-1:8];
         ptr_in        = cnt_ff;
         hit_in        = 1'b0;
         res_status_in = ST_DONE;
         res_count_in  = '0;
         res_found_in  = 1'b0;
      end

      if (cmd.push) begin
         if (cnt_ff == CNT_W'(DEPTH)) begin
            res_status_in = ST_FULL;
         end else begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[IDX_W-1:0];
            wr_data = key_ff;
            cnt_in  = cnt_ff + CNT_W'(1);
         end
      end

      if (cmd.pop) begin
         if (cnt_ff == '0) begin
            res_status_in = ST_EMPTY;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end

      if (cmd.length) begin
         res_count_in = cnt_ff;
      end

      if (cmd.scan && (ptr_ff != '0)) begin
         rd_en       = 1'b1;
         rd_addr     = ptr_dec[IDX_W-1:0];
         rd_idx_in   = ptr_dec[IDX_W-1:0];
         rd_shift_in = 1'b0;
         ptr_in      = ptr_dec;
      end

      if (cmd.not_found) begin
         res_status_in = ST_NOT_FOUND;
      end

      if (cmd.shift_start) begin
         ptr_in = CNT_W'(hit_idx_ff) + CNT_W'(1);
      end

      if (cmd.shift && (ptr_ff < cnt_ff)) begin
         rd_en       = 1'b1;
         rd_addr     = ptr_ff[IDX_W-1:0];
         rd_idx_in   = ptr_ff[IDX_W-1:0];
         rd_shift_in = 1'b1;
         ptr_in      = ptr_ff + CNT_W'(1);
      end

      if (cmd.shift_end) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end

      rd_vld_in = rd_en;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.respond) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'({res_found_ff, PCOUNT_W'(res_count_ff), res_status_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         sq_vld_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         sq_vld_ff    <= sq_vld_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      lim_ff        <= lim_in;
      ptr_ff        <= ptr_in;
      rd_shift_ff   <= rd_shift_in;
      rd_idx_ff     <= rd_idx_in;
      sqx_ff        <= sqx_in;
      sqy_ff        <= sqy_in;
      hit_idx_ff    <= hit_idx_in;
      res_status_ff <= res_status_in;
      res_count_ff  <= res_count_in;
      res_found_ff  <= res_found_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign sts.op         = op_ff;
   assign sts.hit        = hit_ff;
   assign sts.scan_idle  = (ptr_ff == '0) && !rd_vld_ff && !sq_vld_ff;
   assign sts.shift_idle = (ptr_ff >= cnt_ff) && !rd_vld_ff;
   assign sts.rsp_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/core/psrq_controller.sv */
`timescale 1ns / 1ps

module psrq_controller
   import psrq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  psrq_sts_type sts,
   output psrq_cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXEC  = 5'b00010,
      S_SCAN  = 5'b00100,
      S_SHIFT = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (sts.op)
               OP_PUSH: begin
                  cmd.push = 1'b1;
                  state_in = S_DONE;
               end
               OP_POP: begin
                  cmd.pop  = 1'b1;
                  state_in = S_DONE;
               end
               OP_LENGTH: begin
                  cmd.length = 1'b1;
                  state_in   = S_DONE;
               end
               OP_REMOVE, OP_COUNT, OP_SEARCH: begin
                  state_in = S_SCAN;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SCAN: begin
            if (sts.hit) begin
               if (sts.op == OP_REMOVE) begin
                  cmd.shift_start = 1'b1;
                  state_in        = S_SHIFT;
               end else begin
                  state_in = S_DONE;
               end
            end else if (sts.scan_idle) begin
               if (sts.op == OP_REMOVE) begin
                  cmd.not_found = 1'b1;
               end
               state_in = S_DONE;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         S_SHIFT: begin
            if (sts.shift_idle) begin
               cmd.shift_end = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.shift = 1'b1;
            end
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

/* rtl/core/psrq_checker.sv */
`timescale 1ns / 1ps

module psrq_checker
   import psrq_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled result keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Only one request is in flight: ready drops after each acceptance.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");

   // Nothing is presented right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A found flag only comes with a clean status and no count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[STATUS_W + PCOUNT_W] |->
         (rsp_tdata[STATUS_W-1:0] == ST_DONE) &&
         (rsp_tdata[STATUS_W +: PCOUNT_W] == '0))
      else $error("found with bad status or count");

   // A count never exceeds the store depth, and failures carry no count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         (rsp_tdata[STATUS_W +: PCOUNT_W] <= PCOUNT_W'(DEPTH)) &&
         ((rsp_tdata[STATUS_W-1:0] == ST_DONE) ||
          (rsp_tdata[STATUS_W +: PCOUNT_W] == '0)))
      else $error("count out of range");

endmodule

bind point_stack_radius_query_unit psrq_checker u_psrq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
